FILE: rtl/sensor_poll_motion_tilt_qualifier_core_macros.svh
// Assertion macros shared by the sensor poll qualifier RTL.
`ifndef SENSOR_POLL_MOTION_TILT_QUALIFIER_CORE_MACROS_SVH
`define SENSOR_POLL_MOTION_TILT_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPMTQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spmtq: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPMTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spmtq: next-cycle check failed");

`endif

FILE: rtl/spmtq_pkg.sv
// Shared types and constants for the sensor poll qualifier.
package spmtq_pkg;

	localparam int ADC_BITS_DEF = 12;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FLAT_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_MOVING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_STILL  = 2'd2;

	// Register reset values
	localparam int FLAT_LEVEL_RST = 2048;
	localparam int TOL_MOVING_RST = 32;
	localparam int TOL_STILL_RST  = 64;

	// Tilt band half-widths around the flat level
	localparam int TILT_NEAR = 'h50;
	localparam int TILT_MID  = 'hF0;
	localparam int TILT_FAR  = 'h190;

	// Event codes: opened / motion started, closed / motion stopped
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_RISE = 2'd1,
		EV_FALL = 2'd2
	} ev_code_t;

	// Status part of one result, door_event in the lowest bits
	typedef struct packed {
		logic       tilt_changed;
		logic [2:0] tilt_leds;
		logic       open_indicator;
		logic       is_moving;
		logic       window_is_open;
		logic       door_is_open;
		ev_code_t   motion_event;
		ev_code_t   window_event;
		ev_code_t   door_event;
	} status_t;

endpackage

FILE: rtl/spmtq_cfg.sv
// Configuration registers: flat level and the two motion tolerances.
module spmtq_cfg #(
	parameter int ADC_BITS = spmtq_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [spmtq_pkg::CFG_IDX_W-1:0]    index,
	input  logic [ADC_BITS-1:0]                data,
	output logic [ADC_BITS-1:0]                flat_level,
	output logic [ADC_BITS-1:0]                tol_moving,
	output logic [ADC_BITS-1:0]                tol_still
);
	import spmtq_pkg::*;

	logic [ADC_BITS-1:0] flat_q;
	logic [ADC_BITS-1:0] tol_moving_q;
	logic [ADC_BITS-1:0] tol_still_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q       <= ADC_BITS'(FLAT_LEVEL_RST);
			tol_moving_q <= ADC_BITS'(TOL_MOVING_RST);
			tol_still_q  <= ADC_BITS'(TOL_STILL_RST);
		end else if (wr_en) begin
			// indexes past the list are dropped
			unique case (index)
				REG_FLAT_LEVEL: flat_q       <= data;
				REG_TOL_MOVING: tol_moving_q <= data;
				REG_TOL_STILL:  tol_still_q  <= data;
				default: ;
			endcase
		end
	end

	assign flat_level = flat_q;
	assign tol_moving = tol_moving_q;
	assign tol_still  = tol_still_q;

endmodule

FILE: rtl/spmtq_qual.sv
// Poll evaluation: switch edges, motion hysteresis and confirmation, tilt bands.
module spmtq_qual #(
	parameter int ADC_BITS = spmtq_pkg::ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  door,
	input  logic                  window,
	input  logic [ADC_BITS-1:0]   accel_x,
	input  logic [ADC_BITS-1:0]   accel_y,
	input  logic [ADC_BITS-1:0]   accel_z,
	input  logic [ADC_BITS-1:0]   flat_level,
	input  logic [ADC_BITS-1:0]   tol_moving,
	input  logic [ADC_BITS-1:0]   tol_still,
	output spmtq_pkg::status_t    status
);
	import spmtq_pkg::*;

	// Wide enough for flat level plus the widest band without wrap
	localparam int CW = ((ADC_BITS > 9) ? ADC_BITS : 9) + 1;

	logic prev_door_q, prev_window_q;
	logic door_open_q, window_open_q, open_led_q, moving_q;
	logic [ADC_BITS-1:0] last_x_q, last_y_q, last_z_q;
	logic hist_new_q, hist_old_q;
	logic [2:0] tilt_q;

	logic door_rise, door_fall, win_rise, win_fall;
	logic door_open_d, window_open_d, open_led_d, moving_d;
	logic [ADC_BITS-1:0] tol, dx, dy, dz;
	logic raw;
	logic stop_hit, start_hit;
	logic [CW-1:0] y_w, f_w;
	logic [2:0] leds;
	ev_code_t door_ev, win_ev, motion_ev;

	always_comb begin
		door_rise = door & ~prev_door_q;
		door_fall = ~door & prev_door_q;
		win_rise  = window & ~prev_window_q;
		win_fall  = ~window & prev_window_q;

		door_ev       = door_rise ? EV_RISE : (door_fall ? EV_FALL : EV_NONE);
		win_ev        = win_rise ? EV_RISE : (win_fall ? EV_FALL : EV_NONE);
		door_open_d   = door_rise | (door_open_q & ~door_fall);
		window_open_d = win_rise | (window_open_q & ~win_fall);

		// window edge wins over a door edge in the same poll
		priority if (win_rise)  open_led_d = 1'b1;
		else if (win_fall)      open_led_d = 1'b0;
		else if (door_rise)     open_led_d = 1'b1;
		else if (door_fall)     open_led_d = 1'b0;
		else                    open_led_d = open_led_q;
	end

	// Raw motion against the hysteresis tolerance
	always_comb begin
		tol = moving_q ? tol_moving : tol_still;
		dx  = (accel_x > last_x_q) ? accel_x - last_x_q : last_x_q - accel_x;
		dy  = (accel_y > last_y_q) ? accel_y - last_y_q : last_y_q - accel_y;
		dz  = (accel_z > last_z_q) ? accel_z - last_z_q : last_z_q - accel_z;
		raw = (dx > tol) | (dy > tol) | (dz > tol);

		// stop on 1,0,0 while moving, start on 0,1,1 while still
		stop_hit  = hist_old_q & ~hist_new_q & ~raw & moving_q;
		start_hit = ~hist_old_q & hist_new_q & raw & ~moving_q;
		moving_d  = start_hit | (moving_q & ~stop_hit);
		motion_ev = stop_hit ? EV_FALL : (start_hit ? EV_RISE : EV_NONE);
	end

	// Tilt bands, lower bound tested as y + band < flat to avoid wrap
	always_comb begin
		y_w = CW'(accel_y);
		f_w = CW'(flat_level);
		leds[0] = (y_w + CW'(TILT_FAR) < f_w)  | (y_w > f_w + CW'(TILT_NEAR));
		leds[1] = (y_w + CW'(TILT_MID) < f_w)  | (y_w > f_w + CW'(TILT_MID));
		leds[2] = (y_w + CW'(TILT_NEAR) < f_w) | (y_w > f_w + CW'(TILT_FAR));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_door_q   <= 1'b0;
			prev_window_q <= 1'b0;
			door_open_q   <= 1'b0;
			window_open_q <= 1'b0;
			open_led_q    <= 1'b0;
			moving_q      <= 1'b0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			last_z_q      <= '0;
			hist_new_q    <= 1'b0;
			hist_old_q    <= 1'b0;
			tilt_q        <= '0;
		end else if (advance) begin
			prev_door_q   <= door;
			prev_window_q <= window;
			door_open_q   <= door_open_d;
			window_open_q <= window_open_d;
			open_led_q    <= open_led_d;
			moving_q      <= moving_d;
			last_x_q      <= accel_x;
			last_y_q      <= accel_y;
			last_z_q      <= accel_z;
			hist_new_q    <= raw;
			hist_old_q    <= hist_new_q;
			tilt_q        <= leds;
		end
	end

	always_comb begin
		status.door_event     = door_ev;
		status.window_event   = win_ev;
		status.motion_event   = motion_ev;
		status.door_is_open   = door_open_d;
		status.window_is_open = window_open_d;
		status.is_moving      = moving_d;
		status.open_indicator = open_led_d;
		status.tilt_leds      = leds;
		status.tilt_changed   = (leds != tilt_q);
	end

endmodule

FILE: rtl/sensor_poll_motion_tilt_qualifier_core.sv
// Sensor poll qualifier top level: input stage, evaluation, result stage.
//
// Usage:
//   One poll sample enters on the s_axis channel per transfer and one status
//   result leaves on the m_axis channel for every poll, in order.
//   Configuration (flat level, moving and still tolerances) is written through
//   cfg_wr_en / cfg_index / cfg_data while no poll is in flight; writes to an
//   index past the register list are dropped.
// Flow and throughput:
//   A poll accepted into the input stage is held there and evaluated while
//   the result stage is free or draining; its result is registered into the
//   result stage and shows on m_axis. One poll per cycle is sustained while
//   m_tready stays high; a single evaluation pass lies between the input and
//   result stages.
// Reset:
//   arst_n clears both stages, all switch, motion and tilt history and loads
//   the register defaults (flat 2048, tolerances 32 and 64).
// Stall:
//   While m_tready is low the result is held and one more poll may still be
//   taken into the input stage; s_tready then drops until the result leaves.
module sensor_poll_motion_tilt_qualifier_core #(
	parameter int ADC_BITS = spmtq_pkg::ADC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// fields from bit 0: door_switch, window_switch, accel_x, accel_y, accel_z,
	// pot_level, zero fill
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2 + 4 * ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// fields from bit 0: door_event, window_event, motion_event, door_is_open,
	// window_is_open, is_moving, open_indicator, tilt_leds, tilt_changed,
	// light_level, zero fill
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((14 + ADC_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                                  cfg_wr_en,
	input  logic [spmtq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ADC_BITS-1:0]                   cfg_data
);
	import spmtq_pkg::*;

	`include "sensor_poll_motion_tilt_qualifier_core_macros.svh"

	localparam int OUT_TW = ((14 + ADC_BITS + 7) / 8) * 8;

	logic                valid_s1;
	logic                door_s1, window_s1;
	logic [ADC_BITS-1:0] x_s1, y_s1, z_s1, pot_s1;
	logic                valid_s2;
	status_t             status_s2;
	logic [ADC_BITS-1:0] light_s2;

	logic                advance;
	status_t             status_d;
	logic [ADC_BITS-1:0] flat_level, tol_moving, tol_still;

	// evaluate the held poll when the result stage is free or draining
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			door_s1   <= s_tdata[0];
			window_s1 <= s_tdata[1];
			x_s1      <= s_tdata[2 +: ADC_BITS];
			y_s1      <= s_tdata[2 + ADC_BITS +: ADC_BITS];
			z_s1      <= s_tdata[2 + 2 * ADC_BITS +: ADC_BITS];
			pot_s1    <= s_tdata[2 + 3 * ADC_BITS +: ADC_BITS];
		end
	end

	spmtq_cfg #(
		.ADC_BITS(ADC_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_wr_en),
		.index      (cfg_index),
		.data       (cfg_data),
		.flat_level (flat_level),
		.tol_moving (tol_moving),
		.tol_still  (tol_still)
	);

	spmtq_qual #(
		.ADC_BITS(ADC_BITS)
	) u_qual (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.door       (door_s1),
		.window     (window_s1),
		.accel_x    (x_s1),
		.accel_y    (y_s1),
		.accel_z    (z_s1),
		.flat_level (flat_level),
		.tol_moving (tol_moving),
		.tol_still  (tol_still),
		.status     (status_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_d;
			light_s2  <= pot_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TW'({light_s2, status_s2});

	`SPMTQ_ASSERT_IMPL(a_stall_only_when_full, !s_tready, valid_s1 && valid_s2 && !m_tready)
	`SPMTQ_ASSERT_NEXT(a_advance_fills_result, advance, m_tvalid)
	`SPMTQ_ASSERT_IMPL(a_start_sets_moving, m_tvalid && status_s2.motion_event == EV_RISE, status_s2.is_moving)
	`SPMTQ_ASSERT_IMPL(a_door_open_sets_flag, m_tvalid && status_s2.door_event == EV_RISE, status_s2.door_is_open)

endmodule
